FILE: design/lpc_pkg.sv
// Types and constants shared by the loop phase clock modules.
package lpc_pkg;

    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned LENGTH_W = 24;
    localparam int unsigned RATIO_W  = 17;
    localparam int unsigned QUO_W    = 16;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned PULSE_W  = 4;
    localparam int unsigned STEP_W   = 4;

    localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_START   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_STOP    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_RESET   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SET_LEN = 3'd4;

    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PLAY = 2'd2;

    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;
    localparam logic [PULSE_W-1:0] PULSE_Q0  = 4'b0001;
    localparam logic [STEP_W-1:0]  DIV_LAST  = 4'd15;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [LENGTH_W-1:0] length_value;
    } lpc_in_t;

    typedef struct packed {
        logic                ratio_valid;
        logic [RATIO_W-1:0]  phase_ratio;
        logic [PULSE_W-1:0]  quarter_pulses;
        logic [MODE_W-1:0]   mode;
    } lpc_out_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic fold;
        logic div_step;
        logic load;
    } lpc_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } lpc_sts_t;

endpackage

FILE: design/loop_phase_clock_top.sv
// Top level of the loop phase clock: controller, datapath and assertions.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  lpc_in_t  (opcode, length_value)
//  m_       out        m_valid / m_ready  lpc_out_t (ratio_valid, phase_ratio,
//                                                    quarter_pulses, mode)
//
// One transaction in flight. A playback tick goes from acceptance through update,
// fold, 16 radix-2 divider steps and load, the divider cut short when the ratio
// saturates; others go from update to load. The next input is taken the cycle after
// the load. A held result stalls only the load of the following transaction.
// Synchronous active-low reset clears the mode, length and counts; no clearing pass.
module loop_phase_clock_top #(
    parameter int unsigned COUNT_WIDTH = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lpc_pkg::lpc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lpc_pkg::lpc_out_t m_data
);
    import lpc_pkg::*;

    lpc_cmd_t cmd;
    lpc_sts_t sts;

    lpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lpc_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_data (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a transaction is in flight");

    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.phase_ratio <= RATIO_ONE)
        else $error("phase ratio above one");

    a_ratio_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.ratio_valid |-> m_data.phase_ratio == '0)
        else $error("phase ratio set without ratio_valid");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !m_valid || m_ready)
        else $error("result register overwritten before transfer");
`endif

endmodule

FILE: design/lpc_ctrl.sv
// Sequencing state machine for the loop phase clock.
module lpc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lpc_pkg::lpc_sts_t sts,
    output lpc_pkg::lpc_cmd_t cmd
);
    import lpc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_FOLD = 5'b00100,
        S_DIV  = 5'b01000,
        S_LOAD = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.need_div ? S_FOLD : S_LOAD;
            end
            S_FOLD: begin
                cmd.fold   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/lpc_datapath.sv
// Loop state, phase fold, radix-2 ratio divider and output register.
module lpc_datapath #(
    parameter int unsigned COUNT_WIDTH = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lpc_pkg::lpc_in_t  in_data,
    input  lpc_pkg::lpc_cmd_t cmd,
    output lpc_pkg::lpc_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output lpc_pkg::lpc_out_t m_data
);
    import lpc_pkg::*;

    localparam int unsigned CW = COUNT_WIDTH;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    logic [OPCODE_W-1:0] op_reg, op_next;
    logic [CW-1:0]       len_in_reg, len_in_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [CW-1:0]       length_reg, length_next;
    logic [CW-1:0]       phase_reg, phase_next;
    logic [CW-1:0]       elapsed_reg, elapsed_next;
    logic [CW:0]         rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_div_reg, pend_div_next;
    logic [PULSE_W-1:0]  pend_pulses_reg, pend_pulses_next;
    logic                sat_reg, sat_next;
    logic                skip_reg, skip_next;
    lpc_out_t            out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [CW-1:0]  length_inc, phase_inc, elapsed_inc;
    logic [CW-1:0]  num, q1, q2, q3;
    logic [CW+1:0]  len_x3;
    logic [CW:0]    len_x2, shifted;
    logic           gt, fold_sat, fold_zero, ge;
    logic [RATIO_W-1:0] ratio_sel;

    assign length_inc  = (length_reg == CNT_MAX) ? length_reg : length_reg + 1'b1;
    assign phase_inc   = (phase_reg == CNT_MAX) ? phase_reg : phase_reg + 1'b1;
    assign elapsed_inc = (elapsed_reg == CNT_MAX) ? elapsed_reg : elapsed_reg + 1'b1;

    // fold stage: one subtraction of the length, saturation decided in parallel
    assign num       = rem_reg[CW-1:0];
    assign len_x2    = {length_reg, 1'b0};
    assign gt        = num > length_reg;
    assign fold_zero = (length_reg == '0);
    assign fold_sat  = gt ? ({1'b0, num} >= len_x2) : (num == length_reg);

    assign q1     = {2'b00, length_reg[CW-1:2]};
    assign q2     = {1'b0, length_reg[CW-1:1]};
    assign len_x3 = {2'b00, length_reg} + {1'b0, length_reg, 1'b0};
    assign q3     = len_x3[CW+1:2];

    assign shifted = {rem_reg[CW-1:0], 1'b0};
    assign ge      = shifted >= {1'b0, length_reg};

    always_comb begin
        if (!pend_div_reg) begin
            ratio_sel = '0;
        end else if (skip_reg) begin
            ratio_sel = sat_reg ? RATIO_ONE : '0;
        end else begin
            ratio_sel = {1'b0, quo_reg};
        end
    end

    always_comb begin
        op_next          = op_reg;
        len_in_next      = len_in_reg;
        mode_next        = mode_reg;
        length_next      = length_reg;
        phase_next       = phase_reg;
        elapsed_next     = elapsed_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_div_next    = pend_div_reg;
        pend_pulses_next = pend_pulses_reg;
        sat_next         = sat_reg;
        skip_next        = skip_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;

        if (cmd.capture) begin
            op_next     = in_data.opcode;
            len_in_next = CW'(in_data.length_value);
        end

        if (cmd.exec) begin
            pend_valid_next  = 1'b0;
            pend_div_next    = 1'b0;
            pend_pulses_next = '0;
            case (op_reg)
                OP_TICK: begin
                    if (mode_reg == MODE_REC) begin
                        length_next = length_inc;
                    end else if (mode_reg == MODE_PLAY) begin
                        rem_next        = {1'b0, phase_inc};
                        pend_valid_next = 1'b1;
                        pend_div_next   = 1'b1;
                        if (elapsed_inc >= length_reg) begin
                            phase_next   = '0;
                            elapsed_next = '0;
                        end else begin
                            phase_next   = phase_inc;
                            elapsed_next = elapsed_inc;
                        end
                    end
                end
                OP_START: begin
                    if (mode_reg == MODE_IDLE && length_reg == '0) begin
                        mode_next = MODE_REC;
                    end else if (length_reg != '0) begin
                        elapsed_next     = '0;
                        mode_next        = MODE_PLAY;
                        pend_pulses_next = PULSE_Q0;
                    end
                end
                OP_STOP: begin
                    mode_next = MODE_IDLE;
                end
                OP_RESET: begin
                    mode_next       = MODE_IDLE;
                    length_next     = '0;
                    phase_next      = '0;
                    elapsed_next    = '0;
                    pend_valid_next = 1'b1;
                end
                OP_SET_LEN: begin
                    if (length_reg == '0 && len_in_reg != '0) begin
                        length_next  = len_in_reg;
                        phase_next   = '0;
                        elapsed_next = '0;
                    end
                end
                default: begin
                    pend_valid_next = 1'b0;
                end
            endcase
        end

        if (cmd.fold) begin
            rem_next  = gt ? {1'b0, num - length_reg} : {1'b0, num};
            sat_next  = fold_sat && !fold_zero;
            skip_next = fold_sat || fold_zero;
            quo_next  = '0;
            cnt_next  = '0;
            pend_pulses_next = {phase_reg == q3, phase_reg == q2,
                                phase_reg == q1, phase_reg == '0};
        end

        if (cmd.div_step) begin
            rem_next = ge ? shifted - {1'b0, length_reg} : shifted;
            quo_next = {quo_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.load) begin
            out_next.ratio_valid    = pend_valid_reg;
            out_next.phase_ratio    = ratio_sel;
            out_next.quarter_pulses = pend_pulses_reg;
            out_next.mode           = mode_reg;
            out_valid_next          = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            length_reg    <= '0;
            phase_reg     <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            length_reg    <= length_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        len_in_reg      <= len_in_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        cnt_reg         <= cnt_next;
        pend_valid_reg  <= pend_valid_next;
        pend_div_reg    <= pend_div_next;
        pend_pulses_reg <= pend_pulses_next;
        sat_reg         <= sat_next;
        skip_reg        <= skip_next;
        out_reg         <= out_next;
    end

    assign sts.need_div = (op_reg == OP_TICK) && (mode_reg == MODE_PLAY);
    assign sts.div_done = skip_reg || (cnt_reg == DIV_LAST);
    assign sts.out_free = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
